@@ hdl/cns_pkg.sv @@
// ----------------------------------------------------------------------------
// cns_pkg: shared types and constants of the cutoff neighbor search
// Item structs, command kinds and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package cns_pkg;

	localparam int MAX_ATOMS  = 64;
	localparam int COORD_BITS = 16;
	localparam int SLOT_W   = 6;
	localparam int COLOR_W  = 8;
	localparam int CUTOFF_W = 15;
	localparam int AIU_W    = 7;
	localparam int CNT_W    = 6;
	localparam int RESULT_CAP = 63;

	localparam logic CFG_CUTOFF = 1'b0;
	localparam logic CFG_AIU    = 1'b1;
	localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 15'd896;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic              kind;
		logic [5:0]        slot;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
	} in_item_t;

	typedef struct packed {
		logic [5:0] central_index;
		logic       neighbor_valid;
		logic [5:0] neighbor_index;
		logic [5:0] neighbor_count;
		logic [7:0] poly_red;
		logic [7:0] poly_green;
		logic [7:0] poly_blue;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_SCAN,
		ST_DRAIN,
		ST_DIVIDE,
		ST_FINAL
	} be_state_t;

endpackage

`default_nettype wire

@@ hdl/cutoff_neighbor_search.sv @@
// ----------------------------------------------------------------------------
// cutoff_neighbor_search: fixed-radius neighbor search over an atom store
// Front end queues items, back end scans the store and emits neighbors.
// ----------------------------------------------------------------------------
// A load item is written to the store while the back end stays idle. A query
// occupies the back end for a scan of atoms_in_use slots (at most 64):
// the store is read one slot per cycle into a two-stage distance pipeline,
// and the final mean colors come from an eight-step serial divider.
// Output back-pressure pauses the scan.
`default_nettype none

module cutoff_neighbor_search
	import cns_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  in_item_t        in_item,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_item,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [14:0] cfg_data
);

	logic [CUTOFF_W-1:0] cutoff_q;
	logic [AIU_W-1:0]    aiu_q;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;
	in_item_t            q_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
			aiu_q    <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CUTOFF) begin
				cutoff_q <= cfg_data;
			end else begin
				aiu_q <= cfg_data[AIU_W-1:0];
			end
		end
	end

	cns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (in_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_data)
	);

	cns_backend u_backend (
		.clk        (clk),
		.arst_n     (arst_n),
		.cutoff_cfg (cutoff_q),
		.aiu_cfg    (aiu_q),
		.cmd_empty  (q_empty),
		.cmd        (q_data),
		.cmd_pop    (q_pop),
		.out_valid  (out_valid),
		.out_item   (out_item),
		.out_stall  (out_stall)
	);

endmodule

`default_nettype wire

@@ hdl/cns_queue.sv @@
// ----------------------------------------------------------------------------
// cns_queue: small command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cns_queue
	import cns_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  in_item_t      push_data,
	output logic          full,
	input  wire logic     pop,
	output logic          empty,
	output in_item_t      pop_data
);

	in_item_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hdl/cns_backend.sv @@
// ----------------------------------------------------------------------------
// cns_backend: atom store and neighbor scan engine
// Executes loads and queries: scans the store one slot per cycle unless held,
// via a two-stage distance pipeline, then divides the color sums serially.
// ----------------------------------------------------------------------------
`default_nettype none

module cns_backend
	import cns_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [CUTOFF_W-1:0] cutoff_cfg,
	input  wire logic [AIU_W-1:0]    aiu_cfg,
	input  wire logic                cmd_empty,
	input  in_item_t                 cmd,
	output logic                     cmd_pop,
	output logic                     out_valid,
	output out_item_t                out_item,
	input  wire logic                out_stall
);

	localparam int AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW   = AW + 1;
	localparam int DW   = COORD_BITS + 1;
	localparam int SQW  = 2 * DW + 2;
	localparam int SUMW = COLOR_W + CNT_W;

	logic [COORD_BITS-1:0] xs_mem [MAX_ATOMS];
	logic [COORD_BITS-1:0] ys_mem [MAX_ATOMS];
	logic [COORD_BITS-1:0] zs_mem [MAX_ATOMS];
	logic [23:0]           col_mem [MAX_ATOMS];

	be_state_t state_q, state_d;

	logic [AW-1:0]  ctr_slot_q;
	logic [CW-1:0]  rd_idx_q;
	logic [CW-1:0]  scan_len_q;
	logic [AW-1:0]  rd_addr;
	logic           rd_en;
	logic [COORD_BITS-1:0] rx_q, ry_q, rz_q;
	logic [23:0]    rc_q;
	logic [COORD_BITS-1:0] cx_q, cy_q, cz_q;

	// pipeline valid/index for read data
	logic           v_s1;
	logic [AW-1:0]  idx_s1;
	logic           v_s2;
	logic [AW-1:0]  idx_s2;
	logic [23:0]    col_s2;
	logic [SQW-1:0] dsq_s2;
	logic           near_s2;

	logic [CNT_W-1:0] found_q;
	logic [SUMW-1:0]  rsum_q, gsum_q, bsum_q;
	logic [SLOT_W-1:0] pend_idx_q;
	logic             pend_q;

	logic [CNT_W-1:0] rrem_q, grem_q, brem_q;
	logic [COLOR_W-1:0] rquo_q, gquo_q, bquo_q;
	logic [3:0]      div_step_q;
	logic [2:0]      div_bit;
	logic [CNT_W:0]  rt, gt, bt;
	logic            rge, gge, bge;

	logic            ov_q;
	out_item_t       ov_item_q;
	logic            can_out;
	logic            hold;

	logic [CUTOFF_W-1:0] cut;
	logic [2*CUTOFF_W-1:0] lim_sq_q;

	assign cut     = cutoff_cfg;
	assign can_out = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign out_item  = ov_item_q;

	// read port control
	always_comb begin
		rd_addr = '0;
		rd_en   = 1'b0;
		if (state_q == ST_IDLE) begin
			rd_addr = cmd.slot[AW-1:0];
		end else if (state_q == ST_SCAN) begin
			rd_addr = rd_idx_q[AW-1:0];
			rd_en   = (rd_idx_q < scan_len_q) && (found_q != CNT_W'(RESULT_CAP));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !cmd_empty && cmd.kind == KIND_LOAD) begin
			xs_mem[cmd.slot[AW-1:0]]  <= cmd.pos_x[COORD_BITS-1:0];
			ys_mem[cmd.slot[AW-1:0]]  <= cmd.pos_y[COORD_BITS-1:0];
			zs_mem[cmd.slot[AW-1:0]]  <= cmd.pos_z[COORD_BITS-1:0];
			col_mem[cmd.slot[AW-1:0]] <= {cmd.red, cmd.green, cmd.blue};
		end
		if (!hold) begin
			rx_q <= xs_mem[rd_addr];
			ry_q <= ys_mem[rd_addr];
			rz_q <= zs_mem[rd_addr];
			rc_q <= col_mem[rd_addr];
		end
	end

	// distance pipeline: stage 1 absolute differences, stage 2 squares
	logic signed [DW-1:0] dx, dy, dz;
	logic [DW-1:0] ax, ay, az;
	logic [DW-1:0] ax_s2, ay_s2, az_s2;
	logic          big_s2;

	assign dx = DW'($signed(rx_q)) - DW'($signed(cx_q));
	assign dy = DW'($signed(ry_q)) - DW'($signed(cy_q));
	assign dz = DW'($signed(rz_q)) - DW'($signed(cz_q));
	assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign az = dz[DW-1] ? DW'(-dz) : DW'(dz);

	always_ff @(posedge clk) begin
		if (!hold) begin
			ax_s2  <= ax;
			ay_s2  <= ay;
			az_s2  <= az;
			big_s2 <= (ax >= DW'(cut)) || (ay >= DW'(cut)) || (az >= DW'(cut));
			col_s2 <= rc_q;
			idx_s2 <= idx_s1;
		end
		lim_sq_q <= cut * cut;
	end

	assign dsq_s2 = SQW'(ax_s2 * ax_s2) + SQW'(ay_s2 * ay_s2) + SQW'(az_s2 * az_s2);
	assign near_s2 = v_s2 && !big_s2 && (dsq_s2 < SQW'(lim_sq_q))
		&& (found_q != CNT_W'(RESULT_CAP));

	// serial divider: one quotient bit per step for each color
	assign div_bit = 3'(4'd8 - div_step_q);
	assign rt  = {rrem_q, rsum_q[div_bit]};
	assign gt  = {grem_q, gsum_q[div_bit]};
	assign bt  = {brem_q, bsum_q[div_bit]};
	assign rge = rt >= {1'b0, found_q};
	assign gge = gt >= {1'b0, found_q};
	assign bge = bt >= {1'b0, found_q};

	// state machine
	logic scan_done;
	assign scan_done = (!rd_en) && !v_s1 && !v_s2;

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.kind == KIND_QUERY) begin
						state_d = ST_CENTER;
					end
				end
			end
			ST_CENTER: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DRAIN: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (div_step_q == 4'd8) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (can_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Back-pressure: a found neighbor is held in pend until the output register
	// takes it; the scan halts if another is found while pend is held and blocked.
	assign hold = pend_q && !can_out && near_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			pend_q     <= 1'b0;
			ov_q       <= 1'b0;
			found_q    <= '0;
			rd_idx_q   <= '0;
			div_step_q <= '0;
		end else begin
			state_q <= state_d;
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					found_q  <= '0;
					rd_idx_q <= '0;
					v_s1     <= 1'b0;
					v_s2     <= 1'b0;
					pend_q   <= 1'b0;
				end
				ST_SCAN: begin
					if (!hold) begin
						v_s1 <= rd_en && (rd_idx_q[AW-1:0] != ctr_slot_q);
						v_s2 <= v_s1;
						if (rd_en) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
						if (near_s2) begin
							found_q <= found_q + 1'b1;
							if (pend_q) begin
								ov_q <= 1'b1;
							end
							pend_q <= 1'b1;
						end
					end
				end
				ST_DIVIDE: div_step_q <= div_step_q + 1'b1;
				ST_FINAL: begin
					if (can_out) begin
						ov_q   <= 1'b1;
						pend_q <= 1'b0;
					end
					div_step_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// scan stalls by freezing all of stage regs when hold is set
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			ctr_slot_q <= cmd.slot[AW-1:0];
			scan_len_q <= (aiu_cfg > AIU_W'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(aiu_cfg);
			rsum_q <= '0;
			gsum_q <= '0;
			bsum_q <= '0;
		end
		if (state_q == ST_CENTER) begin
			cx_q <= rx_q;
			cy_q <= ry_q;
			cz_q <= rz_q;
		end
		if (state_q == ST_SCAN && !hold) begin
			idx_s1 <= rd_addr;
			if (near_s2) begin
				rsum_q <= rsum_q + SUMW'(col_s2[23:16]);
				gsum_q <= gsum_q + SUMW'(col_s2[15:8]);
				bsum_q <= bsum_q + SUMW'(col_s2[7:0]);
				pend_idx_q <= SLOT_W'(idx_s2);
				if (pend_q) begin
					ov_item_q <= '{central_index: SLOT_W'(ctr_slot_q), neighbor_valid: 1'b1,
						neighbor_index: pend_idx_q, default: '0};
				end
			end
		end
		if (state_q == ST_DIVIDE) begin
			if (div_step_q == 4'd0) begin
				rrem_q <= rsum_q[SUMW-1:COLOR_W];
				grem_q <= gsum_q[SUMW-1:COLOR_W];
				brem_q <= bsum_q[SUMW-1:COLOR_W];
				rquo_q <= '0; gquo_q <= '0; bquo_q <= '0;
			end else begin
				rrem_q <= rge ? CNT_W'(rt - {1'b0, found_q}) : rt[CNT_W-1:0];
				grem_q <= gge ? CNT_W'(gt - {1'b0, found_q}) : gt[CNT_W-1:0];
				brem_q <= bge ? CNT_W'(bt - {1'b0, found_q}) : bt[CNT_W-1:0];
				rquo_q <= {rquo_q[COLOR_W-2:0], rge};
				gquo_q <= {gquo_q[COLOR_W-2:0], gge};
				bquo_q <= {bquo_q[COLOR_W-2:0], bge};
			end
		end
		if (state_q == ST_FINAL && can_out) begin
			ov_item_q <= '{central_index: SLOT_W'(ctr_slot_q),
				neighbor_valid: (found_q != '0),
				neighbor_index: (found_q != '0) ? pend_idx_q : '0,
				neighbor_count: found_q,
				poly_red:   (found_q != '0) ? 8'd255 - rquo_q : 8'd128,
				poly_green: (found_q != '0) ? 8'd255 - gquo_q : 8'd128,
				poly_blue:  (found_q != '0) ? 8'd255 - bquo_q : 8'd128,
				last: 1'b1};
		end
	end

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL && can_out) |=> (ov_q && ov_item_q.last))
		else $error("final item missing last");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= CNT_W'(RESULT_CAP)) else $error("neighbor count over cap");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q) else $error("output dropped");

endmodule

`default_nettype wire
